// ===== rtl/lpr_pkg.sv =====
// Shared constants and command/status types for the LRU page replacement block.
`default_nettype none

package lpr_pkg;

  // Number of page frames and the widths that follow from it.
  localparam int FRAMES  = 8;
  localparam int IDX_W   = 3;
  localparam int AGE_W   = 3;
  localparam int PAGE_W  = 16;
  localparam int CFG_W   = 4;
  localparam int FAULT_W = 32;

  localparam logic [AGE_W-1:0]   AGE_MAX    = AGE_W'(FRAMES - 1);
  localparam logic [CFG_W-1:0]   CFG_FRAMES = CFG_W'(FRAMES);
  localparam logic [FAULT_W-1:0] FAULT_MAX  = '1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // register the incoming transaction
    logic commit;   // resolve the held reference and update the frames
  } lpr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;  // the result register can take a new result this cycle
  } lpr_stat_t;

endpackage

`default_nettype wire

// ===== rtl/lpr_ctrl.sv =====
// Controller state machine: sequences capture and commit of each reference.
`default_nettype none

module lpr_ctrl (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  output logic                in_ready,
  input  lpr_pkg::lpr_stat_t  stat,
  output lpr_pkg::lpr_cmd_t   cmd
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_CALC = 2'b10
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    // Nothing is taken while reset is held, so no transaction can be lost.
    in_ready    = (state == S_IDLE) && !rst;
    cmd.capture = in_valid && (state == S_IDLE) && !rst;
    cmd.commit  = (state == S_CALC) && stat.out_free;
    state_next  = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_CALC;
        end
      end
      S_CALC: begin
        // Wait here while the previous result is still unclaimed.
        if (stat.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/lpr_dpath.sv =====
// Datapath: frame table, lookup, victim choice, age update and result register.
`default_nettype none

module lpr_dpath (
  input  wire                                clk,
  input  wire                                rst,
  input  lpr_pkg::lpr_cmd_t                  cmd,
  output lpr_pkg::lpr_stat_t                 stat,
  input  wire                                cfg_write_en,
  input  wire [lpr_pkg::CFG_W-1:0]           cfg_write_data,
  input  wire [lpr_pkg::PAGE_W-1:0]          page_number,
  input  wire                                restart,
  output logic                               out_valid,
  input  wire                                out_ready,
  output logic                               hit,
  output logic [lpr_pkg::IDX_W-1:0]          frame_index,
  output logic                               evicted_valid,
  output logic [lpr_pkg::PAGE_W-1:0]         evicted_page,
  output logic [lpr_pkg::FAULT_W-1:0]        fault_total
);

  // Configuration and frame state.
  logic [lpr_pkg::CFG_W-1:0]   frames_in_use;
  logic [lpr_pkg::PAGE_W-1:0]  frame_page [lpr_pkg::FRAMES];
  logic [lpr_pkg::FRAMES-1:0]  frame_valid;
  logic [lpr_pkg::AGE_W-1:0]   frame_age [lpr_pkg::FRAMES];
  logic [lpr_pkg::FAULT_W-1:0] fault_count;

  // Held reference.
  logic [lpr_pkg::PAGE_W-1:0]  item_page;
  logic                        item_restart;

  // Lookup results.
  logic [lpr_pkg::CFG_W-1:0]   active_n;
  logic [lpr_pkg::FRAMES-1:0]  in_use;
  logic [lpr_pkg::FRAMES-1:0]  valid_eff;
  logic [lpr_pkg::AGE_W-1:0]   age_eff [lpr_pkg::FRAMES];
  logic [lpr_pkg::FAULT_W-1:0] fault_eff;
  logic                        hit_any;
  logic [lpr_pkg::IDX_W-1:0]   hit_idx;
  logic                        empty_any;
  logic [lpr_pkg::IDX_W-1:0]   empty_idx;
  logic [lpr_pkg::IDX_W-1:0]   victim_idx;
  logic [lpr_pkg::AGE_W-1:0]   victim_age;
  logic [lpr_pkg::IDX_W-1:0]   sel_idx;
  logic [lpr_pkg::AGE_W-1:0]   old_age;
  logic                        evict;
  logic [lpr_pkg::FRAMES-1:0]  valid_next;
  logic [lpr_pkg::AGE_W-1:0]   age_next [lpr_pkg::FRAMES];
  logic [lpr_pkg::FAULT_W-1:0] fault_next;

  assign stat.out_free = !out_valid || out_ready;

  always_comb begin
    // A zero count means one frame; anything above the frame count saturates.
    if (frames_in_use == '0) begin
      active_n = lpr_pkg::CFG_W'(1);
    end else if (frames_in_use > lpr_pkg::CFG_FRAMES) begin
      active_n = lpr_pkg::CFG_FRAMES;
    end else begin
      active_n = frames_in_use;
    end

    // A restart clears the frames before the reference is looked up.
    valid_eff = item_restart ? '0 : frame_valid;
    fault_eff = item_restart ? '0 : fault_count;
    for (int k = 0; k < lpr_pkg::FRAMES; k++) begin
      in_use[k]  = lpr_pkg::CFG_W'(k) < active_n;
      age_eff[k] = item_restart ? '0 : frame_age[k];
    end

    // Lowest-numbered matching frame and lowest-numbered empty frame.
    hit_any   = 1'b0;
    hit_idx   = '0;
    empty_any = 1'b0;
    empty_idx = '0;
    for (int k = lpr_pkg::FRAMES - 1; k >= 0; k--) begin
      if (in_use[k] && valid_eff[k] && (frame_page[k] == item_page)) begin
        hit_any = 1'b1;
        hit_idx = lpr_pkg::IDX_W'(k);
      end
      if (in_use[k] && !valid_eff[k]) begin
        empty_any = 1'b1;
        empty_idx = lpr_pkg::IDX_W'(k);
      end
    end

    // Oldest frame in use, lowest index on a tie.
    victim_idx = '0;
    victim_age = age_eff[0];
    for (int k = 1; k < lpr_pkg::FRAMES; k++) begin
      if (in_use[k] && (age_eff[k] > victim_age)) begin
        victim_idx = lpr_pkg::IDX_W'(k);
        victim_age = age_eff[k];
      end
    end

    evict = 1'b0;
    if (hit_any) begin
      sel_idx = hit_idx;
      old_age = age_eff[hit_idx];
    end else if (empty_any) begin
      sel_idx = empty_idx;
      old_age = lpr_pkg::AGE_MAX;
    end else begin
      sel_idx = victim_idx;
      old_age = victim_age;
      evict   = 1'b1;
    end

    valid_next = valid_eff;
    if (!hit_any) begin
      valid_next[sel_idx] = 1'b1;
    end

    // Frames younger than the referenced one grow one step older.
    for (int k = 0; k < lpr_pkg::FRAMES; k++) begin
      if (lpr_pkg::IDX_W'(k) == sel_idx) begin
        age_next[k] = '0;
      end else if (in_use[k] && valid_eff[k] && (age_eff[k] < old_age) &&
                   (age_eff[k] < lpr_pkg::AGE_MAX)) begin
        age_next[k] = age_eff[k] + lpr_pkg::AGE_W'(1);
      end else begin
        age_next[k] = age_eff[k];
      end
    end

    if (!hit_any && (fault_eff != lpr_pkg::FAULT_MAX)) begin
      fault_next = fault_eff + lpr_pkg::FAULT_W'(1);
    end else begin
      fault_next = fault_eff;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      frames_in_use <= lpr_pkg::CFG_FRAMES;
      frame_valid   <= '0;
      frame_age     <= '{default: '0};
      fault_count   <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        frames_in_use <= cfg_write_data;
      end
      if (cmd.commit) begin
        frame_valid <= valid_next;
        frame_age   <= age_next;
        fault_count <= fault_next;
        out_valid   <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_page    <= page_number;
      item_restart <= restart;
    end
    if (cmd.commit) begin
      if (!hit_any) begin
        frame_page[sel_idx] <= item_page;
      end
      hit           <= hit_any;
      frame_index   <= sel_idx;
      evicted_valid <= evict;
      evicted_page  <= evict ? frame_page[victim_idx] : '0;
      fault_total   <= fault_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/lru_page_replacement.sv =====
// Top level of the LRU page replacement block: controller plus datapath.
//
//   Channel   Direction  Handshake              Payload
//   in        input      in_valid / in_ready    page_number, restart
//   out       output     out_valid / out_ready  hit, frame_index, evicted_valid,
//                                               evicted_page, fault_total
//   cfg       input      cfg_write_en           cfg_write_data (frames_in_use)
//
// For each reference the input transaction is first registered; then the
// frame lookup, victim choice and age update run, and the result is
// loaded into the output register.
// No new transaction is taken until the held one has been resolved; the
// single-entry reference register and the frame table update set that limit.
// When the output register still holds an unclaimed result, the update waits
// until out_ready frees it, and no new input is taken meanwhile.
// Reset is synchronous: it empties all frames, clears ages and the fault
// count, sets frames_in_use to eight and drops out_valid.
`default_nettype none

module lru_page_replacement (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                in_valid,
  output logic                               in_ready,
  input  wire [lpr_pkg::PAGE_W-1:0]          page_number,
  input  wire                                restart,
  output logic                               out_valid,
  input  wire                                out_ready,
  output logic                               hit,
  output logic [lpr_pkg::IDX_W-1:0]          frame_index,
  output logic                               evicted_valid,
  output logic [lpr_pkg::PAGE_W-1:0]         evicted_page,
  output logic [lpr_pkg::FAULT_W-1:0]        fault_total,
  input  wire                                cfg_write_en,
  input  wire [lpr_pkg::CFG_W-1:0]           cfg_write_data
);

  // Commands run from controller to datapath; status comes back.
  lpr_pkg::lpr_cmd_t  cmd;
  lpr_pkg::lpr_stat_t stat;

  lpr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  lpr_dpath u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .page_number    (page_number),
    .restart        (restart),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .hit            (hit),
    .frame_index    (frame_index),
    .evicted_valid  (evicted_valid),
    .evicted_page   (evicted_page),
    .fault_total    (fault_total)
  );

endmodule

`default_nettype wire

// ===== rtl/lpr_checker.sv =====
// Port-level assertions for the LRU page replacement block, bound to the top level.
`default_nettype none

module lpr_checker (
  input wire                          clk,
  input wire                          rst,
  input wire                          out_valid,
  input wire                          out_ready,
  input wire                          hit,
  input wire [lpr_pkg::IDX_W-1:0]     frame_index,
  input wire                          evicted_valid,
  input wire [lpr_pkg::PAGE_W-1:0]    evicted_page,
  input wire [lpr_pkg::FAULT_W-1:0]   fault_total
);

  // No result appears straight out of reset.
  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid high after reset");

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(hit) &&
      $stable(frame_index) && $stable(evicted_page) && $stable(fault_total)))
    else $error("stalled result changed");

  // A hit never evicts.
  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    (out_valid && hit) |-> !evicted_valid)
    else $error("eviction reported on a hit");

  // A fault is always counted.
  a_miss_counted: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !hit) |-> (fault_total != '0))
    else $error("fault without a count");

  // No eviction means a zero evicted page.
  a_evict_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !evicted_valid) |-> (evicted_page == '0))
    else $error("evicted page not zero");

endmodule

bind lru_page_replacement lpr_checker u_lpr_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .hit           (hit),
  .frame_index   (frame_index),
  .evicted_valid (evicted_valid),
  .evicted_page  (evicted_page),
  .fault_total   (fault_total)
);

`default_nettype wire
